>>> src/sigmoid_neuron_dot_product_assert.svh
// Assertion macros used by the checker of the neuron block.
`ifndef SIGMOID_NEURON_DOT_PRODUCT_ASSERT_SVH
`define SIGMOID_NEURON_DOT_PRODUCT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SND_ASSERT_NOW(label, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond_a) |-> (cond_b)) else $error("neuron check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SND_ASSERT_NEXT(label, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond_a) |=> (cond_b)) else $error("neuron check failed");

`endif

>>> src/snd_pkg.sv
package snd_pkg;

    localparam int MAX_INPUTS     = 64;
    localparam int WIDX_W         = $clog2(MAX_INPUTS);
    localparam int POS_W          = $clog2(MAX_INPUTS + 1);
    localparam int SIG_DEPTH      = 256;
    localparam int SIG_IDX_W      = $clog2(SIG_DEPTH);

    localparam int VALUE_W        = 16;
    localparam int COUNT_W        = 7;
    localparam int ACC_W          = 40;
    localparam int PROD_W         = 2 * VALUE_W;
    localparam int OUT_W          = 16;
    localparam int ACT_FRAC_SHIFT = 12;

    // Activation window [-8, 8) in Q4.24.
    localparam int ACT_WIN_W      = 28;

    localparam int S_TDATA_W      = 24;
    localparam int M_TDATA_W      = 56;
    localparam int CFG_DATA_W     = 16;

    typedef enum logic [0:0] {
        CFG_BIAS        = 1'b0,
        CFG_INPUT_COUNT = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        OP_WEIGHT = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef logic [OUT_W-1:0] sig_table_t [SIG_DEPTH];

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // Restoring long division of unsigned 64-bit operands, quotient truncated.
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Truncated Taylor series of exp(-t), Q30 in and out.
    function automatic logic [63:0] exp_neg_q30(logic [63:0] t);
        logic [63:0] term;
        logic signed [63:0] sum;
        term = Q30_ONE;
        sum  = $signed(Q30_ONE);
        for (int n = 1; n <= 24; n++)
        begin
            term = udiv64((term * t) >> 30, 64'(n));
            if ((n & 1) == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        return (sum < 0) ? 64'd0 : 64'(sum);
    endfunction

    // Sigmoid at each bin center over [-8, 8), unsigned Q0.16, rounded.
    function automatic sig_table_t sig_table_build();
        sig_table_t tbl;
        logic [63:0] e1;
        logic [63:0] mag;
        logic [63:0] u;
        logic [63:0] k;
        logic [63:0] e;
        logic [63:0] s;
        logic [63:0] q;
        int          n;
        e1 = exp_neg_q30(Q30_ONE);
        for (int i = 0; i < SIG_DEPTH; i++)
        begin
            n   = 2 * i + 1 - SIG_DEPTH;
            mag = 64'((n < 0) ? -n : n);
            u   = udiv64((64'd8 * mag) << 30, 64'(SIG_DEPTH));
            k   = u >> 30;
            e   = exp_neg_q30(u & (Q30_ONE - 64'd1));
            for (int j = 0; j < 8; j++)
            begin
                if (64'(j) < k)
                    e = (e * e1) >> 30;
            end
            if (n >= 0)
                s = udiv64(64'd1 << 60, Q30_ONE + e);
            else
                s = udiv64(e << 30, Q30_ONE + e);
            q = (s + 64'd8192) >> 14;
            tbl[i] = (q > 64'd65535) ? 16'hFFFF : q[OUT_W-1:0];
        end
        return tbl;
    endfunction

    localparam sig_table_t SIG_TABLE = sig_table_build();

endpackage

>>> src/sigmoid_neuron_dot_product.sv
// A sample request marked last shows its result on m_tvalid once it has passed the weight
// read, multiply, accumulate and sigmoid lookup into the output register.
// Throughput: one request per cycle; the two-entry output register and skid stage
// stall s_tready only when both hold results that m_tready has not taken.
// Reset (rst_n low, asynchronous): weights read as zero, bias 0, input_count 64,
// sum cleared, element position zero, pipeline and output empty.
module sigmoid_neuron_dot_product
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [5:0] weight_index, [21:6] value, [23:22] zero
    input  logic [snd_pkg::S_TDATA_W-1:0]       s_tdata,
    // [0] op
    input  logic [0:0]                          s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [39:0] activation, [55:40] neuron_output
    output logic [snd_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                cfg_we,
    input  snd_pkg::cfg_index_t                 cfg_index,
    input  logic [snd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import snd_pkg::*;

    localparam logic signed [ACC_W-1:0] ACT_HI  = ACC_W'((64'sd1 <<< (ACT_WIN_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] ACT_LO  = ACC_W'(-(64'sd1 <<< (ACT_WIN_W - 1)));
    localparam logic [ACC_W-1:0]        ACT_OFF = ACC_W'(64'd1 << (ACT_WIN_W - 1));
    localparam int                      IDX_PROD_W = ACT_WIN_W + $clog2(SIG_DEPTH + 1);

    // Configuration.
    logic signed [VALUE_W-1:0]  bias_reg;
    logic [COUNT_W-1:0]         input_count_reg;

    // Weight store with one valid bit per entry.
    logic signed [VALUE_W-1:0]  weight_mem [MAX_INPUTS];
    logic [MAX_INPUTS-1:0]      wvalid_reg;
    logic [POS_W-1:0]           pos_reg;
    logic [POS_W-1:0]           pos_next;

    // Pipeline.
    logic                       s1_valid_reg;
    logic                       s1_last_reg;
    logic                       s1_use_reg;
    logic                       s1_wvalid_reg;
    logic signed [VALUE_W-1:0]  s1_weight_reg;
    logic signed [VALUE_W-1:0]  s1_value_reg;
    logic                       s2_valid_reg;
    logic                       s2_last_reg;
    logic signed [PROD_W-1:0]   s2_prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       res_valid_reg;
    logic signed [ACC_W-1:0]    res_act_reg;

    // Output register and skid stage.
    logic                       out_valid_reg;
    logic [ACC_W-1:0]           out_act_reg;
    logic [OUT_W-1:0]           out_nout_reg;
    logic                       skid_valid_reg;
    logic [ACC_W-1:0]           skid_act_reg;
    logic [OUT_W-1:0]           skid_nout_reg;

    logic                       en;
    logic                       accept;
    logic                       is_sample;
    logic [WIDX_W-1:0]          in_widx;
    logic signed [VALUE_W-1:0]  in_value;
    logic [POS_W-1:0]           limit;
    logic                       in_range;
    logic signed [VALUE_W-1:0]  w_eff;
    logic signed [ACC_W:0]      sum_wide;
    logic signed [ACC_W-1:0]    sum_sat;
    logic signed [ACC_W-1:0]    bias_q24;
    logic signed [ACC_W-1:0]    act_clamped;
    logic [ACT_WIN_W-1:0]       act_off;
    logic [IDX_PROD_W-1:0]      idx_prod;
    logic [SIG_IDX_W-1:0]       sig_idx;
    logic [OUT_W-1:0]           res_nout;
    logic                       pop;

    assign en        = !skid_valid_reg;
    assign s_tready  = en;
    assign accept    = s_tvalid && s_tready;
    assign is_sample = (op_t'(s_tuser) == OP_SAMPLE);
    assign in_widx   = s_tdata[WIDX_W-1:0];
    assign in_value  = s_tdata[WIDX_W +: VALUE_W];

    assign limit    = (input_count_reg > COUNT_W'(MAX_INPUTS)) ? POS_W'(MAX_INPUTS)
                                                                 : POS_W'(input_count_reg);
    assign in_range = (pos_reg < limit);
    assign bias_q24 = {{(ACC_W - VALUE_W - ACT_FRAC_SHIFT){bias_reg[VALUE_W-1]}},
                       bias_reg, {ACT_FRAC_SHIFT{1'b0}}};

    always_comb
    begin
        if (s_tlast)
            pos_next = '0;
        else if (pos_reg < POS_W'(MAX_INPUTS))
            pos_next = pos_reg + POS_W'(1);
        else
            pos_next = pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg        <= '0;
            input_count_reg <= COUNT_W'(MAX_INPUTS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BIAS:        bias_reg        <= cfg_data[VALUE_W-1:0];
                CFG_INPUT_COUNT: input_count_reg <= cfg_data[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Weight store: write on weight requests, registered read at the element position.
    always_ff @(posedge clk)
    begin
        if (accept && !is_sample)
            weight_mem[in_widx] <= in_value;
        if (accept)
            s1_weight_reg <= weight_mem[pos_reg[WIDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg <= '0;
            pos_reg    <= '0;
        end
        else if (accept)
        begin
            if (!is_sample)
                wvalid_reg[in_widx] <= 1'b1;
            else
                pos_reg <= pos_next;
        end
    end

    // Stage 1: operands of the multiply.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= accept && is_sample;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg   <= s_tlast;
            s1_use_reg    <= in_range;
            s1_wvalid_reg <= wvalid_reg[pos_reg[WIDX_W-1:0]];
            s1_value_reg  <= in_value;
        end
    end

    // Stage 2: product.
    assign w_eff = (s1_use_reg && s1_wvalid_reg) ? s1_weight_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en && s1_valid_reg)
        begin
            s2_last_reg <= s1_last_reg;
            s2_prod_reg <= s1_value_reg * w_eff;
        end
    end

    // Stage 3: saturating accumulate.
    assign sum_wide = {acc_reg[ACC_W-1], acc_reg}
                    + {{(ACC_W + 1 - PROD_W){s2_prod_reg[PROD_W-1]}}, s2_prod_reg};

    always_comb
    begin
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1])
            sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                      : {1'b0, {(ACC_W - 1){1'b1}}};
        else
            sum_sat = sum_wide[ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // Write bias only while idle (unchecked); it reloads a sum not yet started.
            if (cfg_we && cfg_index == CFG_BIAS && pos_reg == '0)
                acc_reg <= {{(ACC_W - VALUE_W - ACT_FRAC_SHIFT){cfg_data[VALUE_W-1]}},
                            cfg_data[VALUE_W-1:0], {ACT_FRAC_SHIFT{1'b0}}};
            else if (en && s2_valid_reg)
                acc_reg <= s2_last_reg ? bias_q24 : sum_sat;
            if (en)
                res_valid_reg <= s2_valid_reg && s2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s2_valid_reg && s2_last_reg)
            res_act_reg <= sum_sat;
    end

    // Sigmoid lookup on the clamped activation.
    always_comb
    begin
        if (res_act_reg > ACT_HI)
            act_clamped = ACT_HI;
        else if (res_act_reg < ACT_LO)
            act_clamped = ACT_LO;
        else
            act_clamped = res_act_reg;
    end

    assign act_off  = ACT_WIN_W'(act_clamped + ACT_OFF);
    assign idx_prod = IDX_PROD_W'(act_off) * IDX_PROD_W'(SIG_DEPTH);
    assign sig_idx  = idx_prod[ACT_WIN_W +: SIG_IDX_W];
    assign res_nout = SIG_TABLE[sig_idx];

    // Output register with a skid stage behind it.
    assign pop = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (pop)
                    skid_valid_reg <= 1'b0;
            end
            else if (res_valid_reg)
            begin
                if (!out_valid_reg || pop)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_act_reg  <= skid_act_reg;
                out_nout_reg <= skid_nout_reg;
            end
        end
        else if (res_valid_reg)
        begin
            if (!out_valid_reg || pop)
            begin
                out_act_reg  <= res_act_reg;
                out_nout_reg <= res_nout;
            end
            else
            begin
                skid_act_reg  <= res_act_reg;
                skid_nout_reg <= res_nout;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_nout_reg, out_act_reg};

endmodule

>>> src/snd_checker.sv
`include "sigmoid_neuron_dot_product_assert.svh"

module snd_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [snd_pkg::M_TDATA_W-1:0]       m_tdata
);
    import snd_pkg::*;

    // A result that is not taken stays offered.
    `SND_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid)

    // Input stalls only while both output slots are full.
    `SND_ASSERT_NOW(a_stall_has_result, !s_tready, m_tvalid)

    // A full skid drains as soon as the consumer takes one result.
    `SND_ASSERT_NEXT(a_stall_clears, !s_tready && m_tready, s_tready)

    // Negative activations map below one half, the rest at or above it.
    `SND_ASSERT_NOW(a_sigmoid_side, m_tvalid,
        m_tdata[ACC_W-1] != m_tdata[ACC_W + OUT_W - 1])

endmodule

bind sigmoid_neuron_dot_product snd_checker u_snd_checker (.*);

>>> tb/sigmoid_neuron_dot_product_tb.sv
module sigmoid_neuron_dot_product_tb;
    import snd_pkg::*;

    localparam int CYCLE_LIMIT        = 400000;
    localparam int DRAIN_CYCLES       = 8;
    localparam int RANDOM_REQUESTS    = 650;
    localparam int PHASE_REQUESTS     = 70;
    localparam int DIRECTED_ROWS      = 19;
    localparam int REPORT_LIMIT       = 10;

    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint SUM_MAX   = 64'sd549755813887;
    localparam longint SUM_MIN   = -64'sd549755813888;
    localparam longint ACT_HALF  = 64'sd134217728;

    // Packed so that the layout matches m_tdata: activation in the low bits.
    typedef struct packed {
        logic [OUT_W-1:0] sig;
        logic [ACC_W-1:0] act;
    } neuron_out_t;

    typedef struct {
        op_t               op;
        logic [WIDX_W-1:0] widx;
        logic [VALUE_W-1:0] val;
        logic              last;
        bit                pinned;
        logic [ACC_W-1:0]  act;
    } directed_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    cfg_index_t            cfg_index = CFG_BIAS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state.
    logic signed [VALUE_W-1:0] weight_mem [MAX_INPUTS];
    logic [OUT_W-1:0]          sigmoid_lut [SIG_DEPTH];
    longint                    sum_q824;
    longint                    bias_q412;
    int                        element_pos;
    int                        input_count_reg;

    neuron_out_t pending_outputs [$];
    int          mismatch_count = 0;
    int          requests_sent = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          stall_left = 0;
    int          stall_mode = 0;
    logic [7:0]  ready_mask = 8'hFF;

    sigmoid_neuron_dot_product u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver stalls: always ready, a rotating mask, or random, switching now and then.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            ready_mask = 8'($urandom) | 8'h01;
            stall_left = $urandom_range(32, 200);
        end
        stall_left = stall_left - 1;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1:
            begin
                m_tready <= ready_mask[0];
                ready_mask = {ready_mask[0], ready_mask[7:1]};
            end
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic report_mismatch(input string field, input logic [63:0] want_v,
                                   input logic [63:0] got_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch on %s at cycle %0d: expected %h, got %h",
                     field, cycle_count, want_v, got_v);
    endtask

    always @(posedge clk)
    begin
        neuron_out_t got;
        neuron_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_outputs.size() == 0)
                report_mismatch("unexpected result", 'x, got);
            else
            begin
                want = pending_outputs.pop_front();
                if (got.act !== want.act)
                    report_mismatch("activation", want.act, got.act);
                if (got.sig !== want.sig)
                    report_mismatch("neuron_output", want.sig, got.sig);
            end
        end
    end

    function automatic longint unsigned taylor_exp_neg(input longint unsigned t);
        longint unsigned term;
        longint          acc;
        term = ONE_Q30;
        acc  = longint'(ONE_Q30);
        for (int n = 1; n <= 24; n++)
        begin
            term = ((term * t) >> 30) / longint'(n);
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        return (acc < 0) ? 64'd0 : longint'(acc);
    endfunction

    // Returns 1 when the request produces a result, and fills res with it.
    function automatic bit predict_neuron(input op_t op, input logic [WIDX_W-1:0] widx,
                                          input logic signed [VALUE_W-1:0] val,
                                          input logic last, output neuron_out_t res);
        int     used;
        longint act_win;
        int     lut_idx;
        res = '0;
        used = (input_count_reg > MAX_INPUTS) ? MAX_INPUTS : input_count_reg;
        if (op == OP_WEIGHT)
        begin
            weight_mem[widx] = val;
            return 1'b0;
        end
        if (element_pos < used)
        begin
            sum_q824 = sum_q824 + longint'(val) * longint'(weight_mem[element_pos]);
            if (sum_q824 > SUM_MAX)
                sum_q824 = SUM_MAX;
            if (sum_q824 < SUM_MIN)
                sum_q824 = SUM_MIN;
        end
        if (element_pos < MAX_INPUTS)
            element_pos++;
        if (!last)
            return 1'b0;
        // The table only spans [-8, 8); anything outside lands in the end bins.
        act_win = sum_q824;
        if (act_win < -ACT_HALF)
            act_win = -ACT_HALF;
        if (act_win > ACT_HALF - 1)
            act_win = ACT_HALF - 1;
        lut_idx = int'((act_win + ACT_HALF) >>> (ACT_WIN_W - SIG_IDX_W));
        res.act = sum_q824[ACC_W-1:0];
        res.sig = sigmoid_lut[lut_idx];
        sum_q824 = bias_q412 * 4096;
        element_pos = 0;
        return 1'b1;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_q412();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3, 4: return 16'($urandom_range(0, 16'h2000)) - 16'h1000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_request(input op_t op, input logic [WIDX_W-1:0] widx,
                                input logic [VALUE_W-1:0] val, input logic last,
                                input bit pinned = 1'b0,
                                input logic [ACC_W-1:0] pinned_act = '0);
        neuron_out_t res;
        int          gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - VALUE_W - WIDX_W){1'b0}}, val, widx};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        requests_sent++;
        if (predict_neuron(op, widx, val, last, res))
        begin
            if (pinned)
                res.act = pinned_act;
            pending_outputs.push_back(res);
        end
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(0, 15);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == CFG_BIAS)
        begin
            bias_q412 = longint'($signed(data));
            // A vector already under way keeps its old starting value.
            if (element_pos == 0)
                sum_q824 = bias_q412 * 4096;
        end
        else
            input_count_reg = int'(data[COUNT_W-1:0]);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        directed_row_t   rows [DIRECTED_ROWS];
        longint unsigned e1;
        longint unsigned e;
        longint unsigned u;
        longint unsigned k;
        longint unsigned s;
        longint unsigned q;
        int              n;
        int              mag;
        int              phase;
        int              phase_start;
        int              vec_len;
        logic [CFG_DATA_W-1:0] bias_w;
        logic [CFG_DATA_W-1:0] count_w;

        // Sigmoid at each bin center, Q30 arithmetic truncated, final result rounded.
        e1 = taylor_exp_neg(ONE_Q30);
        for (int i = 0; i < SIG_DEPTH; i++)
        begin
            n   = 2 * i + 1 - SIG_DEPTH;
            mag = (n < 0) ? -n : n;
            u   = ((64'd8 * longint'(mag)) << 30) / longint'(SIG_DEPTH);
            k   = u >> 30;
            e   = taylor_exp_neg(u & (ONE_Q30 - 64'd1));
            for (longint unsigned j = 0; j < k; j++)
                e = (e * e1) >> 30;
            if (n >= 0)
                s = (64'd1 << 60) / (ONE_Q30 + e);
            else
                s = (e << 30) / (ONE_Q30 + e);
            q = (s + 64'd8192) >> 14;
            sigmoid_lut[i] = (q > 64'd65535) ? 16'hFFFF : q[OUT_W-1:0];
        end

        foreach (weight_mem[i])
            weight_mem[i] = '0;
        bias_q412       = 0;
        input_count_reg = 64;
        sum_q824        = 0;
        element_pos     = 0;

        // Activations pinned here are plain sums of products at reset settings.
        rows = '{
            '{OP_SAMPLE, 6'd0,  16'h7FFF, 1'b1, 1'b1, 40'sd0},
            '{OP_WEIGHT, 6'd0,  16'h7FFF, 1'b1, 1'b0, 40'sd0},
            '{OP_WEIGHT, 6'd63, 16'h8000, 1'b0, 1'b0, 40'sd0},
            '{OP_WEIGHT, 6'd1,  16'h8000, 1'b0, 1'b0, 40'sd0},
            '{OP_SAMPLE, 6'd63, 16'h7FFF, 1'b0, 1'b0, 40'sd0},
            '{OP_SAMPLE, 6'd0,  16'h8000, 1'b0, 1'b0, 40'sd0},
            '{OP_SAMPLE, 6'd0,  16'h1234, 1'b1, 1'b1, 40'sd2147418113},
            '{OP_WEIGHT, 6'd0,  16'h8000, 1'b0, 1'b0, 40'sd0},
            '{OP_SAMPLE, 6'd0,  16'h7FFF, 1'b1, 1'b1, -40'sd1073709056},
            '{OP_WEIGHT, 6'd0,  16'h1000, 1'b0, 1'b0, 40'sd0},
            '{OP_WEIGHT, 6'd1,  16'h1000, 1'b0, 1'b0, 40'sd0},
            '{OP_SAMPLE, 6'd0,  16'h1000, 1'b0, 1'b0, 40'sd0},
            '{OP_SAMPLE, 6'd0,  16'hF000, 1'b1, 1'b1, 40'sd0},
            '{OP_SAMPLE, 6'd0,  16'h2000, 1'b1, 1'b1, 40'sd33554432},
            '{OP_SAMPLE, 6'd0,  16'hE000, 1'b1, 1'b1, -40'sd33554432},
            '{OP_SAMPLE, 6'd0,  16'h8000, 1'b1, 1'b1, -40'sd134217728},
            '{OP_SAMPLE, 6'd0,  16'h7FFF, 1'b1, 1'b1, 40'sd134213632},
            '{OP_WEIGHT, 6'd0,  16'hFFFF, 1'b0, 1'b0, 40'sd0},
            '{OP_SAMPLE, 6'd0,  16'h0001, 1'b1, 1'b1, -40'sd1}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
            send_request(rows[r].op, rows[r].widx, rows[r].val, rows[r].last,
                         rows[r].pinned, rows[r].act);

        phase = 0;
        requests_sent = 0;
        while (requests_sent < RANDOM_REQUESTS)
        begin
            wait_idle();
            bias_w = 16'($urandom);
            case (phase % 6)
                0:
                begin
                    bias_w  = 16'h7FFF;
                    count_w = 16'd64;
                end
                1:
                begin
                    bias_w  = 16'h8000;
                    count_w = 16'd1;
                end
                2: count_w = 16'd0;
                3:
                begin
                    bias_w  = 16'($urandom_range(0, 16'h2000)) - 16'h1000;
                    count_w = 16'd127;
                end
                4: count_w = 16'd65;
                default: count_w = 16'($urandom_range(1, 12));
            endcase
            // Bits above the count field are don't-care; toggle them anyway.
            count_w = (16'($urandom) & 16'hFF80) | count_w;
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(CFG_BIAS, bias_w);
                write_reg(CFG_INPUT_COUNT, count_w);
            end
            else
            begin
                write_reg(CFG_INPUT_COUNT, count_w);
                write_reg(CFG_BIAS, bias_w);
            end
            cfg_we <= 1'b0;

            phase_start = requests_sent;
            while (requests_sent - phase_start < PHASE_REQUESTS)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    repeat ($urandom_range(1, 4))
                        send_request(OP_WEIGHT,
                                     ($urandom_range(0, 1) == 1) ? 6'($urandom_range(0, 11))
                                                                 : 6'($urandom),
                                     rand_q412(), 1'($urandom));
                end
                else
                begin
                    vec_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
                                                          : $urandom_range(1, 10);
                    for (int i = 0; i < vec_len; i++)
                    begin
                        // Weight updates may land in the middle of a vector.
                        if ($urandom_range(0, 15) == 0)
                            send_request(OP_WEIGHT, 6'($urandom), rand_q412(), 1'($urandom));
                        send_request(OP_SAMPLE, 6'($urandom), rand_q412(), i == vec_len - 1);
                    end
                end
            end

            // Leave a vector open so the next bias write arrives mid-vector.
            if (phase % 3 == 2 || $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    send_request(OP_SAMPLE, 6'($urandom), rand_q412(), 1'b0);
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
